// ----- rtl/tmcm_pkg.sv -----
// shared constants, types and hash function of the tile mode color block
package tmcm_pkg;

   localparam int MAX_TILE_PIXELS = 4096;
   localparam int IDX_W           = $clog2(MAX_TILE_PIXELS);
   localparam int USED_W          = $clog2(MAX_TILE_PIXELS + 1);
   localparam int COLOR_W         = 32;
   localparam int CNT_W           = 13;
   localparam int EPOCH_W         = 8;

   localparam logic [CNT_W-1:0]   COUNT_MAX = {CNT_W{1'b1}};
   localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
   localparam logic [EPOCH_W-1:0] EPOCH_NONE = '0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(MAX_TILE_PIXELS - 1);
   localparam int HASH_STEPS = (COLOR_W + IDX_W - 1) / IDX_W;

   // one table slot; epoch none marks a slot that holds nothing
   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [CNT_W-1:0]   count;
      logic [EPOCH_W-1:0] epoch;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_CHECK = 3'b010,
      ST_CLEAR = 3'b100
   } state_type;

   // xor fold of the color down to a table index
   function automatic logic [IDX_W-1:0] color_hash(input logic [COLOR_W-1:0] c);
      logic [IDX_W-1:0] h;
      h = '0;
      for (int k = 0; k < HASH_STEPS; k++) begin
         h = h ^ IDX_W'(c >> (k * IDX_W));
      end
      return h;
   endfunction

endpackage

// ----- rtl/tmcm_ram.sv -----
// color table memory: one write port, one registered read port
module tmcm_ram
   import tmcm_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [MAX_TILE_PIXELS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/tile_mode_color_mosaic.sv -----
// top level: tile mode color finder over a hashed color table
//
// channel   direction  handshake                 word
// req       in         start high and busy low   req_pixel_color, req_tile_last
// rsp       out        rsp_valid one-cycle pulse rsp_fill_color
//
// a pixel probes the hashed table one slot at a time: one
// memory read is issued per cycle and checked the next; collisions walk
// linearly, so a new color into a full table walks all 4096 slots
// after reset a clearing pass over all 4096 slots runs with busy high; the same
// pass runs again after every 255 tiles when the epoch tag wraps
// the result is shown for one cycle; the receiver cannot stall it
module tile_mode_color_mosaic
   import tmcm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [COLOR_W-1:0] req_pixel_color,
   input  logic               req_tile_last,
   output logic               rsp_valid,
   output logic [COLOR_W-1:0] rsp_fill_color
);

   state_type          state_ff, state_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic               last_ff, last_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic [IDX_W-1:0]   probes_ff, probes_in;
   logic [USED_W-1:0]  used_ff, used_in;
   logic [COLOR_W-1:0] best_color_ff, best_color_in;
   logic [CNT_W-1:0]   best_count_ff, best_count_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0] rsp_color_ff, rsp_color_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;

   // check stage decode
   logic             slot_live;
   logic             hit;
   logic [CNT_W-1:0] cnt_next;
   logic             take_best;
   logic             pixel_done;

   tmcm_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      slot_live = (rd_data.epoch == epoch_ff);
      hit       = slot_live && (rd_data.color == color_ff);
      cnt_next  = (rd_data.count == COUNT_MAX) ? COUNT_MAX : rd_data.count + CNT_W'(1);
      take_best = hit && (cnt_next >= CNT_W'(2)) &&
                  ((cnt_next > best_count_ff) ||
                   ((cnt_next == best_count_ff) && (color_ff < best_color_ff)));
      // done on hit, on an empty slot, or after walking the whole table
      pixel_done = !slot_live || hit || (probes_ff == IDX_LAST);
   end

   always_comb begin
      state_in      = state_ff;
      color_in      = color_ff;
      last_in       = last_ff;
      addr_in       = addr_ff;
      probes_in     = probes_ff;
      used_in       = used_ff;
      best_color_in = best_color_ff;
      best_count_in = best_count_ff;
      epoch_in      = epoch_ff;
      rsp_valid_in  = 1'b0;
      rsp_color_in  = rsp_color_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = '{color: color_ff, count: CNT_W'(1), epoch: epoch_ff};
      rd_addr       = addr_ff;

      case (state_ff)
         ST_IDLE: begin
            // read the home slot as the pixel is taken
            rd_addr = color_hash(req_pixel_color);
            if (start) begin
               color_in  = req_pixel_color;
               last_in   = req_tile_last;
               addr_in   = color_hash(req_pixel_color);
               probes_in = '0;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            rd_addr = addr_ff + IDX_W'(1);
            if (hit) begin
               wr_en         = 1'b1;
               wr_data.count = cnt_next;
               if (take_best) begin
                  best_color_in = color_ff;
                  best_count_in = cnt_next;
               end
            end else if (!slot_live && (used_ff < USED_W'(MAX_TILE_PIXELS))) begin
               // new color into the empty slot
               wr_en   = 1'b1;
               used_in = used_ff + USED_W'(1);
            end
            if (pixel_done) begin
               state_in = ST_IDLE;
               if (last_ff) begin
                  rsp_valid_in = 1'b1;
                  if (take_best) begin
                     rsp_color_in = color_ff;
                  end else if (best_count_ff >= CNT_W'(2)) begin
                     rsp_color_in = best_color_ff;
                  end else begin
                     rsp_color_in = '0;
                  end
                  used_in       = '0;
                  best_color_in = '0;
                  best_count_in = '0;
                  if (epoch_ff == EPOCH_MAX) begin
                     // tags wrap: sweep the table before reuse
                     epoch_in = EPOCH_FIRST;
                     addr_in  = '0;
                     state_in = ST_CLEAR;
                  end else begin
                     epoch_in = epoch_ff + EPOCH_W'(1);
                  end
               end
            end else begin
               addr_in   = addr_ff + IDX_W'(1);
               probes_in = probes_ff + IDX_W'(1);
            end
         end
         ST_CLEAR: begin
            wr_en         = 1'b1;
            wr_data.epoch = EPOCH_NONE;
            addr_in       = addr_ff + IDX_W'(1);
            if (addr_ff == IDX_LAST) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            addr_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         addr_ff       <= '0;
         used_ff       <= '0;
         best_color_ff <= '0;
         best_count_ff <= '0;
         epoch_ff      <= EPOCH_FIRST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         used_ff       <= used_in;
         best_color_ff <= best_color_in;
         best_count_ff <= best_count_in;
         epoch_ff      <= epoch_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      color_ff     <= color_in;
      last_ff      <= last_in;
      probes_ff    <= probes_in;
      rsp_color_ff <= rsp_color_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fill_color = rsp_color_ff;

endmodule

// ----- rtl/tmcm_checker.sv -----
// port-level checker for the tile mode color block, with its bind
module tmcm_checker
   import tmcm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [COLOR_W-1:0] rsp_fill_color
);

   // clearing pass starts right out of reset
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("not busy after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without work in progress");

   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_fill_color))
      else $error("fill color unknown while strobed");

endmodule

bind tile_mode_color_mosaic tmcm_checker u_tmcm_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_fill_color (rsp_fill_color)
);

// ----- tb/sv/tb_top.sv -----
// testbench for the tile mode color finder: random tiles checked against a predicted fill color
`timescale 1ns / 1ps

module tb_top;
   import tmcm_pkg::*;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [COLOR_W-1:0] req_pixel_color;
   logic               req_tile_last;
   logic               rsp_valid;
   logic [COLOR_W-1:0] rsp_fill_color;

   tile_mode_color_mosaic u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_pixel_color(req_pixel_color),
      .req_tile_last(req_tile_last),
      .rsp_valid(rsp_valid),
      .rsp_fill_color(rsp_fill_color)
   );

   // one pixel word waiting to be sent
   typedef struct {
      logic [COLOR_W-1:0] color;
      logic               last;
   } pixel_word_type;

   pixel_word_type     pixel_queue[$];
   logic [COLOR_W-1:0] fill_expected[$];

   // predictor state: the distinct colors of the open tile with counts
   logic [COLOR_W-1:0] seen_color[MAX_TILE_PIXELS];
   logic [CNT_W-1:0]   seen_count[MAX_TILE_PIXELS];
   int                 seen_used;
   logic [COLOR_W-1:0] lead_color;
   logic [CNT_W-1:0]   lead_count;

   int  error_count;
   int  idle_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // fold one accepted pixel into the predicted tile and queue its fill color
   task automatic predict_pixel(input logic [COLOR_W-1:0] c, input logic last);
      int idx;
      logic [CNT_W-1:0] n;
      idx = -1;
      for (int i = 0; i < seen_used; i++) begin
         if (seen_color[i] == c) begin
            idx = i;
            break;
         end
      end
      if (idx < 0) begin
         // full table: a new color is simply dropped
         if (seen_used < MAX_TILE_PIXELS) begin
            seen_color[seen_used] = c;
            seen_count[seen_used] = 1;
            seen_used++;
         end
      end else begin
         // counts saturate at the 13-bit ceiling
         if (seen_count[idx] != COUNT_MAX) seen_count[idx] = seen_count[idx] + 1'b1;
         n = seen_count[idx];
         // ties go to the smaller color
         if (n >= 2 && (n > lead_count || (n == lead_count && c < lead_color))) begin
            lead_color = c;
            lead_count = n;
         end
      end
      if (last) begin
         fill_expected.insert(fill_expected.size(), lead_count >= 2 ? lead_color : '0);
         seen_used  = 0;
         lead_color = '0;
         lead_count = '0;
      end
   endtask

   // driver: one word at a time, held until accepted
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_pixel(req_pixel_color, req_tile_last);
            void'(pixel_queue.pop_front());
         end
         if (start && busy) begin
            // hold the word until the block takes it
         end else if (pixel_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
            start           <= 1'b1;
            req_pixel_color <= pixel_queue[0].color;
            req_tile_last   <= pixel_queue[0].last;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: each fill color strobe meets the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (fill_expected.size() == 0) begin
            $display("%0t: unexpected fill color, expected none, actual %h",
                     $time, rsp_fill_color);
            error_count++;
         end else begin
            if (rsp_fill_color !== fill_expected[0]) begin
               $display("%0t: fill color mismatch, expected %h, actual %h",
                        $time, fill_expected[0], rsp_fill_color);
               error_count++;
            end
            void'(fill_expected.pop_front());
         end
      end
   end

   // queue one tile: colors drawn from a small palette so repeats are common
   task automatic add_tile(input int len, input int palette_size, input logic [COLOR_W-1:0] base);
      pixel_word_type w;
      logic [COLOR_W-1:0] palette[16];
      for (int i = 0; i < 16; i++) palette[i] = $urandom();
      palette[0] = base;
      for (int i = 0; i < len; i++) begin
         w.color = palette[$urandom_range(palette_size - 1)];
         // occasional noise pixel that almost surely stays unique
         if ($urandom_range(9) == 0) w.color = $urandom();
         w.last  = (i == len - 1);
         pixel_queue.insert(pixel_queue.size(), w);
      end
   endtask

   task automatic add_word(input logic [COLOR_W-1:0] c, input logic last);
      pixel_word_type w;
      w.color = c;
      w.last  = last;
      pixel_queue.insert(pixel_queue.size(), w);
   endtask

   task automatic drain;
      while (pixel_queue.size() != 0 || start) @(posedge clock);
      while (fill_expected.size() != 0) @(posedge clock);
   endtask

   initial begin
      int phase_pct[4];
      phase_pct = '{0, 73, 0, 25};
      reset           = 1'b1;
      start           = 1'b0;
      req_pixel_color = '0;
      req_tile_last   = 1'b0;
      error_count     = 0;
      idle_pct        = 0;
      seen_used       = 0;
      lead_color      = '0;
      lead_count      = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: single pixel tile, all-ones repeats, tie to smaller color, no repeat
      add_word('0, 1'b1);
      add_word(32'hFFFF_FFFF, 1'b0);
      add_word(32'hFFFF_FFFF, 1'b1);
      add_word(32'h8000_0001, 1'b0);
      add_word(32'h0000_0005, 1'b0);
      add_word(32'h0000_0005, 1'b0);
      add_word(32'h8000_0001, 1'b0);
      add_word(32'h0000_0000, 1'b1);
      add_word(32'h1234_5678, 1'b0);
      add_word(32'h8765_4321, 1'b0);
      add_word(32'h0000_0000, 1'b1);
      // a color that repeats and then gets overtaken
      add_word(32'hAAAA_5555, 1'b0);
      add_word(32'hAAAA_5555, 1'b0);
      add_word(32'h5555_AAAA, 1'b0);
      add_word(32'h5555_AAAA, 1'b0);
      add_word(32'h5555_AAAA, 1'b1);
      // colors that fold to the same table index
      add_word(32'h0000_1001, 1'b0);
      add_word(32'h0000_0000, 1'b0);
      add_word(32'h0000_1001, 1'b0);
      add_word(32'h0000_0000, 1'b1);
      drain();

      // random short tiles over four idling phases; enough tiles to wrap the epoch tag
      for (int p = 0; p < 4; p++) begin
         idle_pct = phase_pct[p];
         for (int t = 0; t < 70; t++)
            add_tile($urandom_range(1, 6), $urandom_range(1, 4), $urandom());
         drain();
      end

      // one longer tile of distinct colors, then a late repeat wins
      idle_pct = 0;
      for (int i = 0; i < 64; i++) add_word(32'h0100_0000 + i, 1'b0);
      add_word(32'hDEAD_BEEF, 1'b0);
      add_word(32'hDEAD_BEEF, 1'b0);
      add_word(32'h0100_0003, 1'b0);
      add_word(32'h0100_0003, 1'b1);
      drain();

      repeat (50) @(posedge clock);
      if (error_count == 0 && fill_expected.size() == 0)
         $display("PASS tile_mode_color_mosaic");
      else
         $display("FAIL tile_mode_color_mosaic");
      $finish;
   end

   // watchdog: table clearing passes and idle phases fit well inside this
   initial begin
      #200ms;
      $display("FAIL tile_mode_color_mosaic");
      $finish;
   end

endmodule
